// File: sv/m3inv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package m3inv_pkg;

   // Element format: signed fixed point, ELEM_WIDTH bits with FRAC_BITS fraction bits.
   localparam int ELEM_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // Widths of the exact intermediate values.
   localparam int PROD_W = 2 * ELEM_WIDTH;
   localparam int COF_W  = 2 * ELEM_WIDTH + 1;
   localparam int CHI_W  = COF_W - ELEM_WIDTH;
   localparam int PART_W = ELEM_WIDTH + CHI_W;
   localparam int DET_W  = 3 * ELEM_WIDTH + 3;
   localparam int NUM_A  = DET_W + ELEM_WIDTH;
   localparam int NUM_B  = COF_W + 2 * FRAC_BITS + 2;
   localparam int NUM_W  = ((NUM_A > NUM_B) ? NUM_A : NUM_B) + 1;
   localparam int RND_W  = ((DET_W > 2 * FRAC_BITS + 1) ? DET_W : 2 * FRAC_BITS + 1) + 1;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;

   // One input word: the matrix in row-major order.
   typedef struct packed {
      elem_type m00;
      elem_type m01;
      elem_type m02;
      elem_type m10;
      elem_type m11;
      elem_type m12;
      elem_type m20;
      elem_type m21;
      elem_type m22;
   } req_type;

   // One result word: inverse, determinant and status.
   typedef struct packed {
      elem_type r00;
      elem_type r01;
      elem_type r02;
      elem_type r10;
      elem_type r11;
      elem_type r12;
      elem_type r20;
      elem_type r21;
      elem_type r22;
      elem_type det_value;
      logic     singular;
      logic     overflow;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/matrix3x3_inverse_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Inverse of a 3x3 signed fixed-point matrix, one matrix per word. The unit is a
// pipeline of ELEM_WIDTH + 10 register stages (42 at the default width) and
// accepts a new word in every cycle unless the result side stalls; the restoring
// divider resolves one quotient bit per stage for all nine inverse elements in
// parallel. The exact determinant is formed from the cofactors, and each inverse
// element is the adjugate entry divided by it, rounded to nearest with ties away
// from zero and saturated. A zero determinant sets singular and zeroes all
// outputs. Each stage holds its word until the next one frees up, so a stall on
// the result side only backs up as far as there are occupied stages.
module matrix3x3_inverse_unit
   import m3inv_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   output rsp_type rsp_data
);

   localparam int EW      = ELEM_WIDTH;
   localparam int FB      = FRAC_BITS;
   localparam int ST_DIV  = 8;
   localparam int DIV_N   = EW + 1;
   localparam int NS      = ST_DIV + DIV_N + 1;
   localparam int ST_OUT  = NS - 1;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [EW-1:0]    quo;
      logic             ovf;
      logic             neg;
   } lane_type;

   typedef struct packed {
      logic [DET_W-1:0] dvs;
      logic             zero;
      logic [EW-1:0]    dval;
      logic             dsat;
   } com_type;

   // Stage control: a stage loads when it is empty or its word moves on.
   logic [NS-1:0] vld_ff;
   logic [NS:0]   adv;

   always_comb begin
      adv[NS] = !rsp_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[ST_OUT];

   // Stage 0: input register.
   elem_type mat_ff [9];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mat_ff[0] <= req_data.m00;
         mat_ff[1] <= req_data.m01;
         mat_ff[2] <= req_data.m02;
         mat_ff[3] <= req_data.m10;
         mat_ff[4] <= req_data.m11;
         mat_ff[5] <= req_data.m12;
         mat_ff[6] <= req_data.m20;
         mat_ff[7] <= req_data.m21;
         mat_ff[8] <= req_data.m22;
      end
   end

   // Stage 1: the eighteen 2x2 minor products.
   logic signed [PROD_W-1:0] prod_in [18];
   logic signed [PROD_W-1:0] prod_ff [18];
   elem_type                 row1_ff [3];

   always_comb begin
      prod_in[0]  = PROD_W'(mat_ff[4]) * PROD_W'(mat_ff[8]);
      prod_in[1]  = PROD_W'(mat_ff[5]) * PROD_W'(mat_ff[7]);
      prod_in[2]  = PROD_W'(mat_ff[2]) * PROD_W'(mat_ff[7]);
      prod_in[3]  = PROD_W'(mat_ff[1]) * PROD_W'(mat_ff[8]);
      prod_in[4]  = PROD_W'(mat_ff[1]) * PROD_W'(mat_ff[5]);
      prod_in[5]  = PROD_W'(mat_ff[2]) * PROD_W'(mat_ff[4]);
      prod_in[6]  = PROD_W'(mat_ff[5]) * PROD_W'(mat_ff[6]);
      prod_in[7]  = PROD_W'(mat_ff[3]) * PROD_W'(mat_ff[8]);
      prod_in[8]  = PROD_W'(mat_ff[0]) * PROD_W'(mat_ff[8]);
      prod_in[9]  = PROD_W'(mat_ff[2]) * PROD_W'(mat_ff[6]);
      prod_in[10] = PROD_W'(mat_ff[2]) * PROD_W'(mat_ff[3]);
      prod_in[11] = PROD_W'(mat_ff[0]) * PROD_W'(mat_ff[5]);
      prod_in[12] = PROD_W'(mat_ff[3]) * PROD_W'(mat_ff[7]);
      prod_in[13] = PROD_W'(mat_ff[4]) * PROD_W'(mat_ff[6]);
      prod_in[14] = PROD_W'(mat_ff[1]) * PROD_W'(mat_ff[6]);
      prod_in[15] = PROD_W'(mat_ff[0]) * PROD_W'(mat_ff[7]);
      prod_in[16] = PROD_W'(mat_ff[0]) * PROD_W'(mat_ff[4]);
      prod_in[17] = PROD_W'(mat_ff[1]) * PROD_W'(mat_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         prod_ff <= prod_in;
         row1_ff <= mat_ff[0:2];
      end
   end

   // Stage 2: adjugate entries, row-major.
   logic signed [COF_W-1:0] cof_in [9];
   logic signed [COF_W-1:0] cof2_ff [9];
   elem_type                row2_ff [3];

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         cof_in[k] = COF_W'(prod_ff[2*k]) - COF_W'(prod_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         cof2_ff <= cof_in;
         row2_ff <= row1_ff;
      end
   end

   // Stage 3: determinant partial products, cofactor split into high and low halves.
   logic signed [PART_W-1:0] phi_in [3];
   logic signed [PART_W-1:0] plo_in [3];
   logic signed [PART_W-1:0] phi_ff [3];
   logic signed [PART_W-1:0] plo_ff [3];
   logic signed [COF_W-1:0]  cof3_ff [9];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         phi_in[j] = PART_W'(row2_ff[j]) * PART_W'($signed(cof2_ff[3*j][COF_W-1:EW]));
         plo_in[j] = PART_W'(row2_ff[j]) * PART_W'($signed({1'b0, cof2_ff[3*j][EW-1:0]}));
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         phi_ff  <= phi_in;
         plo_ff  <= plo_in;
         cof3_ff <= cof2_ff;
      end
   end

   // Stage 4: recombine each partial product pair.
   logic signed [DET_W-1:0] term_in [3];
   logic signed [DET_W-1:0] term_ff [3];
   logic signed [COF_W-1:0] cof4_ff [9];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         term_in[j] = (DET_W'(phi_ff[j]) <<< EW) + DET_W'(plo_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         term_ff <= term_in;
         cof4_ff <= cof3_ff;
      end
   end

   // Stage 5: exact determinant.
   logic signed [DET_W-1:0] det_ff;
   logic signed [COF_W-1:0] cof5_ff [9];

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         det_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
         cof5_ff <= cof4_ff;
      end
   end

   // Stage 6: magnitudes and signs.
   logic [DET_W-1:0] absd_ff;
   logic             dneg_ff;
   logic             dzero_ff;
   logic [COF_W-1:0] absc_ff [9];
   logic [8:0]       cneg_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         dneg_ff  <= det_ff[DET_W-1];
         absd_ff  <= det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
         dzero_ff <= (det_ff == '0);
         for (int k = 0; k < 9; k++) begin
            cneg_ff[k] <= cof5_ff[k][COF_W-1];
            absc_ff[k] <= cof5_ff[k][COF_W-1] ? COF_W'(-cof5_ff[k]) : COF_W'(cof5_ff[k]);
         end
      end
   end

   // Stage 7: dividend and divisor for the rounded quotient; rounded determinant.
   lane_type         lane_in [9];
   com_type          com_in;
   logic [RND_W-1:0] drnd;
   logic [EW-1:0]    dlim;
   logic [EW-1:0]    dmag;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         lane_in[k].rem = (NUM_W'(absc_ff[k]) << (2 * FB + 1)) + NUM_W'(absd_ff);
         lane_in[k].quo = '0;
         lane_in[k].ovf = 1'b0;
         lane_in[k].neg = cneg_ff[k] ^ dneg_ff;
      end
      drnd = (RND_W'(absd_ff) + (RND_W'(1) << (2 * FB - 1))) >> (2 * FB);
      dlim = (EW'(1) << (EW - 1)) - EW'(!dneg_ff);
      com_in.dsat = (drnd > RND_W'(dlim));
      dmag = com_in.dsat ? dlim : drnd[EW-1:0];
      com_in.dval = dneg_ff ? EW'(-dmag) : dmag;
      com_in.dvs  = absd_ff << 1;
      com_in.zero = dzero_ff;
   end

   lane_type pre_ff [9];
   com_type  precom_ff;

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         pre_ff    <= lane_in;
         precom_ff <= com_in;
      end
   end

   // Divider: the first stage flags quotients too large for the element width,
   // then each stage settles one quotient bit, most significant first.
   lane_type div_ff [DIV_N][9];
   com_type  dcom_ff [DIV_N];

   genvar d;
   generate
      for (d = 0; d < DIV_N; d++) begin : g_div
         lane_type         src [9];
         lane_type         nxt [9];
         com_type          csrc;
         logic [NUM_W-1:0] dsh;
         logic             take;

         always_comb begin
            csrc = (d == 0) ? precom_ff : dcom_ff[(d == 0) ? 0 : d - 1];
            for (int k = 0; k < 9; k++) begin
               src[k] = (d == 0) ? pre_ff[k] : div_ff[(d == 0) ? 0 : d - 1][k];
            end
            dsh  = NUM_W'(csrc.dvs) << ((d == 0) ? EW : EW - d);
            take = 1'b0;
            for (int k = 0; k < 9; k++) begin
               nxt[k] = src[k];
               take   = (src[k].rem >= dsh);
               if (d == 0) begin
                  nxt[k].ovf = take;
               end else begin
                  if (take) begin
                     nxt[k].rem = src[k].rem - dsh;
                  end
                  nxt[k].quo = {src[k].quo[EW-2:0], take};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (adv[ST_DIV+d]) begin
               div_ff[d]  <= nxt;
               dcom_ff[d] <= csrc;
            end
         end
      end
   endgenerate

   // Output stage: saturate, restore signs, handle a singular matrix.
   rsp_type       rsp_in;
   elem_type      rv [9];
   logic [8:0]    lsat;
   logic [EW-1:0] qlim;
   logic [EW-1:0] qmag;

   always_comb begin
      qlim = '0;
      qmag = '0;
      for (int k = 0; k < 9; k++) begin
         qlim    = (EW'(1) << (EW - 1)) - EW'(!div_ff[DIV_N-1][k].neg);
         lsat[k] = div_ff[DIV_N-1][k].ovf || (div_ff[DIV_N-1][k].quo > qlim);
         qmag    = lsat[k] ? qlim : div_ff[DIV_N-1][k].quo;
         rv[k]   = div_ff[DIV_N-1][k].neg ? EW'(-qmag) : qmag;
      end
      if (dcom_ff[DIV_N-1].zero) begin
         rsp_in           = '0;
         rsp_in.singular  = 1'b1;
      end else begin
         rsp_in.r00       = rv[0];
         rsp_in.r01       = rv[1];
         rsp_in.r02       = rv[2];
         rsp_in.r10       = rv[3];
         rsp_in.r11       = rv[4];
         rsp_in.r12       = rv[5];
         rsp_in.r20       = rv[6];
         rsp_in.r21       = rv[7];
         rsp_in.r22       = rv[8];
         rsp_in.det_value = dcom_ff[DIV_N-1].dval;
         rsp_in.singular  = 1'b0;
         rsp_in.overflow  = (|lsat) || dcom_ff[DIV_N-1].dsat;
      end
   end

   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import m3inv_pkg::*;

   typedef logic signed [255:0] wide_type;

   localparam elem_type ONE = 32'sh0001_0000;
   localparam elem_type EMAX = 32'sh7fff_ffff;
   localparam elem_type EMIN = 32'sh8000_0000;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_WORDS = 1200;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type result;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;

   rsp_type inverse_queue[$];
   int      mismatches = 0;
   int      sent = 0;
   int      received = 0;
   int      singular_seen = 0;
   int      overflow_seen = 0;
   int      idle_cycles = 0;
   bit      quiet_sender = 1'b0;
   bit      quiet_receiver = 1'b0;

   matrix3x3_inverse_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Rounded quotient, half away from zero, clamped to the element range.
   function automatic elem_type round_div_sat(wide_type n, wide_type d, inout bit ovf);
      bit       neg;
      wide_type an;
      wide_type ad;
      wide_type q;
      wide_type lim;
      neg = (n < 0) != (d < 0);
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q = (2 * an + ad) / (2 * ad);
      lim = neg ? (wide_type'(1) <<< (ELEM_WIDTH - 1))
                : (wide_type'(1) <<< (ELEM_WIDTH - 1)) - 1;
      if (q > lim) begin
         q = lim;
         ovf = 1'b1;
      end
      return neg ? elem_type'(-q) : elem_type'(q);
   endfunction

   // Exact adjugate and determinant, then the scaled, rounded inverse.
   function automatic rsp_type invert_matrix(req_type w);
      wide_type m[9];
      wide_type c[9];
      wide_type det;
      wide_type scale;
      elem_type r[9];
      bit       ovf;
      rsp_type  res;
      m[0] = wide_type'(w.m00); m[1] = wide_type'(w.m01); m[2] = wide_type'(w.m02);
      m[3] = wide_type'(w.m10); m[4] = wide_type'(w.m11); m[5] = wide_type'(w.m12);
      m[6] = wide_type'(w.m20); m[7] = wide_type'(w.m21); m[8] = wide_type'(w.m22);
      c[0] = m[4] * m[8] - m[5] * m[7];
      c[1] = m[2] * m[7] - m[1] * m[8];
      c[2] = m[1] * m[5] - m[2] * m[4];
      c[3] = m[5] * m[6] - m[3] * m[8];
      c[4] = m[0] * m[8] - m[2] * m[6];
      c[5] = m[2] * m[3] - m[0] * m[5];
      c[6] = m[3] * m[7] - m[4] * m[6];
      c[7] = m[1] * m[6] - m[0] * m[7];
      c[8] = m[0] * m[4] - m[1] * m[3];
      det = m[0] * c[0] + m[1] * c[3] + m[2] * c[6];
      res = '0;
      if (det == 0) begin
         res.singular = 1'b1;
         return res;
      end
      ovf = 1'b0;
      scale = wide_type'(1) <<< (2 * FRAC_BITS);
      for (int i = 0; i < 9; i++) r[i] = round_div_sat(c[i] * scale, det, ovf);
      res.r00 = r[0]; res.r01 = r[1]; res.r02 = r[2];
      res.r10 = r[3]; res.r11 = r[4]; res.r12 = r[5];
      res.r20 = r[6]; res.r21 = r[7]; res.r22 = r[8];
      res.det_value = round_div_sat(det, scale, ovf);
      res.overflow = ovf;
      return res;
   endfunction

   // Mostly short gaps, a few long ones, none during a quiet stretch.
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic elem_type rand_small_elem();
      return elem_type'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
   endfunction

   // Drive one word from a falling edge and hold it until accepted.
   task automatic send_matrix(req_type w, bit typed, rsp_type result);
      int gap;
      gap = pick_gap(quiet_sender);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = w;
      do @(posedge clock); while (req_stall);
      inverse_queue.push_back(typed ? result : invert_matrix(w));
      sent++;
      @(negedge clock);
   endtask

   // Result side: random stall at each falling edge.
   always @(negedge clock) begin
      if (!reset) rsp_stall <= (pick_gap(quiet_receiver) != 0);
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      bit      bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         received++;
         if (inverse_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_data);
         end else begin
            want = inverse_queue.pop_front();
            bad = 1'b0;
            for (int k = 0; k < 10; k++) begin
               if (rsp_data[$bits(rsp_type)-1-32*k -: 32] !== want[$bits(rsp_type)-1-32*k -: 32])
                  bad = 1'b1;
            end
            if (rsp_data.singular !== want.singular || rsp_data.overflow !== want.overflow)
               bad = 1'b1;
            if (want.singular) singular_seen++;
            if (want.overflow) overflow_seen++;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h, got %h", want, rsp_data);
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", inverse_queue.size());
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type table_rows[$];
      stim_row_type row;
      req_type      w;
      rsp_type      res;
      elem_type     e;
      int           kind;

      // Directed rows: identity, negated identity, scaled identity and zero.
      row.word = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
      row.typed = 1'b1;
      row.result = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, 1'b0, 1'b0};
      table_rows.push_back(row);
      row.word = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
      row.result = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, -ONE, 1'b0, 1'b0};
      table_rows.push_back(row);
      row.word = '{2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE};
      row.result = '{ONE / 2, 0, 0, 0, ONE / 2, 0, 0, 0, ONE / 2, 8 * ONE, 1'b0, 1'b0};
      table_rows.push_back(row);
      row.word = '0;
      row.result = '0;
      row.result.singular = 1'b1;
      table_rows.push_back(row);
      // Uniform matrices of the extreme values are singular too.
      row.word = '{EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX};
      table_rows.push_back(row);
      row.word = '{EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN};
      table_rows.push_back(row);
      // The rest come from the predictor.
      row.typed = 1'b0;
      // Tiny determinant: det rounds to zero, the inverse saturates.
      row.word = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      table_rows.push_back(row);
      row.word = '{1, 0, 0, 0, -1, 0, 0, 0, 1};
      table_rows.push_back(row);
      // Huge diagonal: the determinant saturates, inverse is tiny.
      row.word = '{EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX};
      table_rows.push_back(row);
      row.word = '{EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN};
      table_rows.push_back(row);
      row.word = '{EMIN, EMAX, 0, EMAX, EMIN, 0, 0, 0, EMIN};
      table_rows.push_back(row);
      row.word = '{EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMIN};
      table_rows.push_back(row);
      // Rank-two matrix with a repeated row.
      row.word = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, ONE, 2 * ONE, 3 * ONE};
      table_rows.push_back(row);
      row.word = '{2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE};
      table_rows.push_back(row);
      row.word = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};
      table_rows.push_back(row);
      row.word = '{3, 0, 0, 0, 3, 0, 0, 0, 3};
      table_rows.push_back(row);
      row.word = '{-1, -1, -1, 0, -1, -1, 0, 0, -1};
      table_rows.push_back(row);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (table_rows[i]) send_matrix(table_rows[i].word, table_rows[i].typed,
                                          table_rows[i].result);

      res = '0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 150 == 0) begin
            quiet_sender = ($urandom_range(0, 2) == 0);
            quiet_receiver = ($urandom_range(0, 2) == 0);
         end
         // Let the pipeline drain completely once before going on.
         if (n == RANDOM_WORDS / 2) begin
            req_valid = 1'b0;
            while (inverse_queue.size() != 0) @(negedge clock);
         end
         kind = $urandom_range(0, 9);
         for (int k = 0; k < 9; k++) begin
            if (kind < 5) e = rand_small_elem();
            else e = elem_type'($urandom);
            w[$bits(req_type)-1-32*k -: 32] = e;
         end
         if (kind == 4) begin
            w.m20 = w.m00; w.m21 = w.m01; w.m22 = w.m02;
         end else if (kind == 3) begin
            w.m01 = 0; w.m02 = 0; w.m10 = 0; w.m12 = 0; w.m20 = 0; w.m21 = 0;
         end else if (kind == 9) begin
            w.m00 = elem_type'($urandom_range(0, 8)) - 4;
            w.m11 = elem_type'($urandom_range(0, 8)) - 4;
         end
         send_matrix(w, 1'b0, res);
      end
      req_valid = 1'b0;

      while (inverse_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d matrices, checked %0d results (%0d singular, %0d saturated)",
               sent, received, singular_seen, overflow_seen);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && inverse_queue.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
